// ===== design/sitoa_pkg.sv =====
// package: shared constants, types and state encoding for the decimal text converter
`timescale 1ns / 1ps
package sitoa_pkg;

	localparam int DEF_WIDTH  = 32;
	localparam int DEF_DIGITS = 10;

	localparam int CHAR_W = 6;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} conv_status_t;

endpackage

// ===== design/sitoa_value_if.sv =====
// interface: input channel carrying one signed integer per transaction
`timescale 1ns / 1ps
interface sitoa_value_if #(
	parameter int WIDTH = sitoa_pkg::DEF_WIDTH
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== design/sitoa_char_if.sv =====
// interface: output channel carrying one ascii character per transaction
`timescale 1ns / 1ps
interface sitoa_char_if;
	logic                            valid;
	logic                            ready;
	logic [sitoa_pkg::CHAR_W-1:0]    character;
	logic                            last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

// ===== design/sitoa_bcd_conv.sv =====
// bit-serial binary to bcd converter using shift and add-3, one input bit per cycle
`timescale 1ns / 1ps
module sitoa_bcd_conv #(
	parameter int WIDTH  = sitoa_pkg::DEF_WIDTH,
	parameter int DIGITS = sitoa_pkg::DEF_DIGITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [WIDTH-1:0]             mag,
	output sitoa_pkg::conv_status_t      status,
	output logic [4*DIGITS-1:0]          bcd
);

	localparam int CW = $clog2(WIDTH + 1);
	localparam int BW = 4 * DIGITS;

	logic [WIDTH-1:0] bin_q;
	logic [BW-1:0]    bcd_q;
	logic [BW-1:0]    adj;
	logic             ovf_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			bin_q <= {bin_q[WIDTH-2:0], 1'b0};
			bcd_q <= {adj[BW-2:0], bin_q[WIDTH-1]};
			ovf_q <= ovf_q | adj[BW-1];
		end
	end

	assign status.done = done_q;
	assign status.ovf  = ovf_q;
	assign bcd         = bcd_q;

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// top level: signed integer to decimal ascii text, one character per output transaction
`timescale 1ns / 1ps
// Takes one WIDTH-bit two's complement integer per input transaction and sends its decimal
// text as ASCII, most significant character first, with last set on the final character.
// Negative values are led by '-', the most negative value prints its full unsigned magnitude,
// zero prints a single '0', and leading zeros are not sent while the magnitude fits in DIGITS
// digits. One number is converted at a time: the input is ready again only after the last
// character has been placed in the output register. The bit-serial shift-and-add-3
// converter runs first; then the digits are captured, the leading-zero scan drops each
// suppressed zero, the sign is sent when negative, each digit is sent, and the block goes
// back to idle. If a magnitude has more than DIGITS digits, only its low DIGITS digits are
// sent, leading zeros included.
module signed_int_to_decimal_ascii #(
	parameter int WIDTH  = sitoa_pkg::DEF_WIDTH,
	parameter int DIGITS = sitoa_pkg::DEF_DIGITS
) (
	input  logic          clk,
	input  logic          arst_n,
	sitoa_value_if.sink   num,
	sitoa_char_if.source  text
);

	localparam int BW = 4 * DIGITS;
	localparam int DW = $clog2(DIGITS + 1);

	sitoa_pkg::state_t       state_q;
	sitoa_pkg::state_t       state_d;
	sitoa_pkg::conv_status_t conv_status;

	logic [WIDTH-1:0]            raw;
	logic [WIDTH-1:0]            mag;
	logic                        start;
	logic [BW-1:0]               conv_bcd;

	logic [BW-1:0]               dig_q;
	logic [DW-1:0]               dcnt_q;
	logic                        neg_q;
	logic                        ovf_q;
	logic [3:0]                  top;

	logic                        in_ready;
	logic                        can_load;
	logic                        load;
	logic                        shift;
	logic                        capture;
	logic [sitoa_pkg::CHAR_W-1:0] out_char;
	logic                        out_last;

	logic                        out_valid_q;
	logic [sitoa_pkg::CHAR_W-1:0] char_q;
	logic                        last_q;

	assign raw   = num.value;
	assign mag   = raw[WIDTH-1] ? (~raw + 1'b1) : raw;
	assign start = num.valid && in_ready;
	assign top   = dig_q[BW-1 -: 4];
	assign can_load = !out_valid_q || text.ready;

	sitoa_bcd_conv #(
		.WIDTH  (WIDTH),
		.DIGITS (DIGITS)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mag    (mag),
		.status (conv_status),
		.bcd    (conv_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load     = 1'b0;
		shift    = 1'b0;
		capture  = 1'b0;
		out_char = sitoa_pkg::CHAR_ZERO + {2'b00, top};
		out_last = (dcnt_q == DW'(1));
		case (state_q)
			sitoa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (num.valid) begin
					state_d = sitoa_pkg::ST_CONV;
				end
			end
			sitoa_pkg::ST_CONV: begin
				if (conv_status.done) begin
					capture = 1'b1;
					state_d = sitoa_pkg::ST_SKIP;
				end
			end
			sitoa_pkg::ST_SKIP: begin
				// drop leading zeros unless the magnitude overflowed the digit buffer
				if (!ovf_q && top == 4'd0 && dcnt_q != DW'(1)) begin
					shift = 1'b1;
				end else if (neg_q) begin
					state_d = sitoa_pkg::ST_SIGN;
				end else begin
					state_d = sitoa_pkg::ST_EMIT;
				end
			end
			sitoa_pkg::ST_SIGN: begin
				if (can_load) begin
					load     = 1'b1;
					out_char = sitoa_pkg::CHAR_MINUS;
					out_last = 1'b0;
					state_d  = sitoa_pkg::ST_EMIT;
				end
			end
			sitoa_pkg::ST_EMIT: begin
				if (can_load) begin
					load  = 1'b1;
					shift = 1'b1;
					if (dcnt_q == DW'(1)) begin
						state_d = sitoa_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sitoa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= raw[WIDTH-1];
		end
		if (capture) begin
			dig_q  <= conv_bcd;
			ovf_q  <= conv_status.ovf;
			dcnt_q <= DW'(DIGITS);
		end else if (shift) begin
			dig_q  <= {dig_q[BW-5:0], 4'd0};
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign num.ready      = in_ready;
	assign text.valid     = out_valid_q;
	assign text.character = char_q;
	assign text.last      = last_q;

endmodule

// ===== design/sitoa_checker.sv =====
// checker: port-level assertions for the decimal text converter, with its bind
`timescale 1ns / 1ps
module sitoa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [sitoa_pkg::CHAR_W-1:0]  out_char,
	input logic                          out_last
);

	// a stalled transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("stalled output changed");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_char == sitoa_pkg::CHAR_MINUS ||
			(out_char >= sitoa_pkg::CHAR_ZERO && out_char <= sitoa_pkg::CHAR_ZERO + 6'd9))
		else $error("character outside minus and digits");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == sitoa_pkg::CHAR_MINUS |-> !out_last)
		else $error("minus sign flagged as last");

	// one number at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a conversion runs");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (num.valid),
	.in_ready  (num.ready),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.out_char  (text.character),
	.out_last  (text.last)
);
